// ===== rtl/hbw_pkg.sv =====
// Heartbeat stall watchdog: shared types, constants and register indexes.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package hbw_pkg;

	localparam int unsigned TimeW     = 32;
	localparam int unsigned HitsW     = 8;
	localparam int unsigned TotalW    = 16;
	localparam int unsigned CfgIdxW   = 2;
	localparam int unsigned CfgDataW  = 32;
	localparam int unsigned InDataW   = 104;
	localparam int unsigned OutDataW  = 40;

	localparam logic [TimeW-1:0]  MinThresholdMs  = 32'd1000;
	localparam logic [TimeW-1:0]  MinIntervalMs   = 32'd5000;
	localparam logic [TimeW-1:0]  RstThresholdMs  = 32'd60000;
	localparam logic [TimeW-1:0]  RstIntervalMs   = 32'd60000;
	localparam logic [HitsW-1:0]  RstHitsLimit    = 8'd3;
	localparam logic [HitsW-1:0]  HitsMax         = 8'hFF;
	localparam logic [TotalW-1:0] TotalMax        = 16'hFFFF;

	typedef enum logic [CfgIdxW-1:0] {
		REG_STALL_THRESHOLD = 2'd0,
		REG_HITS_LIMIT      = 2'd1,
		REG_AUTO_RESTART    = 2'd2,
		REG_SNAP_INTERVAL   = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CAUSE_NONE    = 2'd0,
		CAUSE_MAIN    = 2'd1,
		CAUSE_DISPLAY = 2'd2
	} cause_t;

	typedef struct packed {
		logic [TimeW-1:0] stale_limit_ms;
		logic [HitsW-1:0] hits_before_restart;
		logic             auto_restart_enable;
		logic [TimeW-1:0] snap_period_ms;
	} cfg_t;

	typedef struct packed {
		logic             display_present;
		logic [TimeW-1:0] display_beat_ms;
		logic [TimeW-1:0] main_beat_ms;
		logic [TimeW-1:0] now_ms;
	} tick_t;

	typedef struct packed {
		logic [HitsW-1:0]  main_hits;
		logic [HitsW-1:0]  display_hits;
		logic [TimeW-1:0]  last_snapshot_time;
		logic [TotalW-1:0] restart_total;
	} wd_state_t;

	typedef struct packed {
		logic [TotalW-1:0] restart_total;
		logic              snapshot_due;
		cause_t            restart_cause;
		logic              restart_request;
		logic [HitsW-1:0]  display_hits;
		logic [HitsW-1:0]  main_hits;
	} result_t;

endpackage

// ===== rtl/hbw_cfg.sv =====
// Heartbeat stall watchdog: configuration registers with write-side clamping.
// Depends on hbw_pkg.
`timescale 1ns / 1ps

module hbw_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [hbw_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [hbw_pkg::CfgDataW-1:0]     cfg_wdata,
	output hbw_pkg::cfg_t                    cfg
);
	import hbw_pkg::*;

	cfg_t cfg_q;
	logic [HitsW-1:0] hits_wr;

	assign hits_wr = cfg_wdata[HitsW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stale_limit_ms       <= RstThresholdMs;
			cfg_q.hits_before_restart  <= RstHitsLimit;
			cfg_q.auto_restart_enable  <= 1'b1;
			cfg_q.snap_period_ms       <= RstIntervalMs;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_STALL_THRESHOLD: begin
					cfg_q.stale_limit_ms <= (cfg_wdata < MinThresholdMs) ?
						MinThresholdMs : cfg_wdata;
				end
				REG_HITS_LIMIT: begin
					cfg_q.hits_before_restart <= (hits_wr == '0) ? HitsW'(1) : hits_wr;
				end
				REG_AUTO_RESTART: begin
					cfg_q.auto_restart_enable <= cfg_wdata[0];
				end
				REG_SNAP_INTERVAL: begin
					// zero disables the snapshot timer, small non-zero values clamp up
					cfg_q.snap_period_ms <=
						(cfg_wdata != '0 && cfg_wdata < MinIntervalMs) ?
						MinIntervalMs : cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/hbw_eval.sv =====
// Heartbeat stall watchdog: single-pass evaluation of one tick.
// Combinational; gives the next watchdog state and the result. Depends on hbw_pkg.
`timescale 1ns / 1ps

module hbw_eval (
	input  hbw_pkg::cfg_t      cfg,
	input  hbw_pkg::tick_t     tick,
	input  hbw_pkg::wd_state_t state,
	output hbw_pkg::wd_state_t state_next,
	output hbw_pkg::result_t   result
);
	import hbw_pkg::*;

	logic [TimeW-1:0]  age_main;
	logic [TimeW-1:0]  age_disp;
	logic [TimeW-1:0]  snap_age;
	logic              main_stale;
	logic              disp_stale;
	logic [HitsW-1:0]  main_hits_upd;
	logic [HitsW-1:0]  disp_hits_upd;
	logic              main_rst;
	logic              disp_rst;
	logic              any_rst;
	logic              snap;

	assign age_main = tick.now_ms - tick.main_beat_ms;
	assign age_disp = tick.now_ms - tick.display_beat_ms;
	assign snap_age = tick.now_ms - state.last_snapshot_time;

	assign main_stale = (tick.main_beat_ms != '0) && (age_main > cfg.stale_limit_ms);
	assign disp_stale = tick.display_present && (tick.display_beat_ms != '0) &&
		(age_disp > cfg.stale_limit_ms);

	// saturate at the top, clear on a fresh tick
	assign main_hits_upd = !main_stale ? '0 :
		(state.main_hits == HitsMax) ? HitsMax : state.main_hits + HitsW'(1);
	assign disp_hits_upd = !disp_stale ? '0 :
		(state.display_hits == HitsMax) ? HitsMax : state.display_hits + HitsW'(1);

	assign main_rst = cfg.auto_restart_enable && main_stale &&
		(main_hits_upd >= cfg.hits_before_restart);
	assign disp_rst = !main_rst && cfg.auto_restart_enable && disp_stale &&
		(disp_hits_upd >= cfg.hits_before_restart);
	assign any_rst = main_rst || disp_rst;

	assign snap = !any_rst && (cfg.snap_period_ms != '0) &&
		(snap_age >= cfg.snap_period_ms);

	always_comb begin
		state_next.main_hits = main_hits_upd;
		// a main restart skips the display check, so its counter holds
		state_next.display_hits = main_rst ? state.display_hits : disp_hits_upd;
		state_next.last_snapshot_time = snap ? tick.now_ms : state.last_snapshot_time;
		state_next.restart_total = (any_rst && state.restart_total != TotalMax) ?
			state.restart_total + TotalW'(1) : state.restart_total;
	end

	always_comb begin
		result.main_hits       = state_next.main_hits;
		result.display_hits    = state_next.display_hits;
		result.restart_request = any_rst;
		result.restart_cause   = main_rst ? CAUSE_MAIN : (disp_rst ? CAUSE_DISPLAY : CAUSE_NONE);
		result.snapshot_due    = snap;
		result.restart_total   = state_next.restart_total;
	end

endmodule

// ===== rtl/heartbeat_stall_watchdog_top.sv =====
// Heartbeat stall watchdog: top level with input register, state and result register.
// Depends on hbw_pkg, hbw_cfg and hbw_eval.
//
//   channel   dir  fields (lowest bit first)
//   s_*       in   now_ms[31:0] main_beat_ms[63:32] display_beat_ms[95:64]
//                  display_present[96], zero fill to 104 bits
//   m_*       out  main_hits[7:0] display_hits[15:8] restart_request[16]
//                  restart_cause[18:17] snapshot_due[19] restart_total[35:20],
//                  zero fill to 40 bits
//   cfg_*     in   index 0 threshold, 1 hit limit, 2 auto restart, 3 interval
//
// One tick per cycle sustained while the output accepts; a tick passes from acceptance
// to result through the input register, then the evaluation and state update into the result
// register. Reset clears the watchdog state and loads the register defaults.
// A stalled output holds the result register and the input register; s_tready
// drops only when both are full.
`timescale 1ns / 1ps

module heartbeat_stall_watchdog_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [hbw_pkg::InDataW-1:0]       s_tdata,  // now_ms, main_beat_ms,
	                                                    // display_beat_ms, display_present
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [hbw_pkg::OutDataW-1:0]      m_tdata,  // main_hits, display_hits,
	                                                    // restart_request, restart_cause,
	                                                    // snapshot_due, restart_total
	input  logic                              cfg_we,
	input  logic [hbw_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [hbw_pkg::CfgDataW-1:0]      cfg_wdata
);
	import hbw_pkg::*;

	cfg_t      cfg;
	tick_t     tick_s1;
	logic      valid_s1;
	wd_state_t state_q;
	wd_state_t state_next;
	result_t   result;
	result_t   result_s2;
	logic      valid_s2;
	logic      advance;

	hbw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	hbw_eval u_eval (
		.cfg        (cfg),
		.tick       (tick_s1),
		.state      (state_q),
		.state_next (state_next),
		.result     (result)
	);

	// move a tick into the result register when that slot is free or draining
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			tick_s1 <= tick_t'(s_tdata[$bits(tick_t)-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {(OutDataW - $bits(result_t))'(0), result_s2};

endmodule

// ===== tb/sv/tb_heartbeat_stall_watchdog_top.sv =====
// Self-checking testbench for heartbeat_stall_watchdog_top: drives monitor ticks, predicts
// each result from an internal model of the watchdog and compares every field on output.
// Depends on hbw_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb_heartbeat_stall_watchdog_top;

	import hbw_pkg::*;

	localparam int unsigned PipeDepth  = 2;
	localparam int unsigned QuietLimit = 4000;
	localparam int unsigned HoldCycles = 300;
	localparam int unsigned ResW       = $bits(result_t);

	typedef enum {BEAT_FRESH, BEAT_STALE, BEAT_NEVER, BEAT_NOISE} beat_mode_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [OutDataW-1:0] m_tdata;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_wdata;

	// mirror of the block's registers and watchdog state
	logic [TimeW-1:0]  wd_threshold;
	logic [HitsW-1:0]  wd_hit_limit;
	logic              wd_auto;
	logic [TimeW-1:0]  wd_interval;
	logic [HitsW-1:0]  wd_main_hits;
	logic [HitsW-1:0]  wd_disp_hits;
	logic [TimeW-1:0]  wd_last_snap;
	logic [TotalW-1:0] wd_restarts;

	result_t     verdicts_due[$];
	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned quiet_cycles;
	int unsigned snd_idle_pct;
	int unsigned rcv_stall_pct;
	int unsigned hold_req;
	int unsigned hold_left;

	// random traffic state
	logic [TimeW-1:0] wall_ms;
	beat_mode_t       main_mode;
	beat_mode_t       disp_mode;
	int unsigned      main_left;
	int unsigned      disp_left;

	heartbeat_stall_watchdog_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic channel_stale(logic [TimeW-1:0] now, logic [TimeW-1:0] beat,
			logic active);
		return active && (beat != '0) && ((now - beat) > wd_threshold);
	endfunction

	function automatic result_t watchdog_verdict(tick_t t);
		result_t r;
		cause_t  cause;
		logic    snap;
		cause = CAUSE_NONE;
		snap  = 1'b0;
		if (channel_stale(t.now_ms, t.main_beat_ms, 1'b1)) begin
			if (wd_main_hits != HitsMax) wd_main_hits = wd_main_hits + HitsW'(1);
			if (wd_auto && wd_main_hits >= wd_hit_limit) cause = CAUSE_MAIN;
		end else begin
			wd_main_hits = '0;
		end
		// a main restart leaves the display counter untouched
		if (cause == CAUSE_NONE) begin
			if (channel_stale(t.now_ms, t.display_beat_ms, t.display_present)) begin
				if (wd_disp_hits != HitsMax) wd_disp_hits = wd_disp_hits + HitsW'(1);
				if (wd_auto && wd_disp_hits >= wd_hit_limit) cause = CAUSE_DISPLAY;
			end else begin
				wd_disp_hits = '0;
			end
		end
		if (cause != CAUSE_NONE) begin
			if (wd_restarts != TotalMax) wd_restarts = wd_restarts + TotalW'(1);
		end else if (wd_interval != '0 && (t.now_ms - wd_last_snap) >= wd_interval) begin
			snap = 1'b1;
			wd_last_snap = t.now_ms;
		end
		r.main_hits       = wd_main_hits;
		r.display_hits    = wd_disp_hits;
		r.restart_request = (cause != CAUSE_NONE);
		r.restart_cause   = cause;
		r.snapshot_due    = snap;
		r.restart_total   = wd_restarts;
		return r;
	endfunction

	function automatic tick_t mk_tick(logic [TimeW-1:0] now, logic [TimeW-1:0] main_beat,
			logic [TimeW-1:0] disp_beat, logic present);
		tick_t t;
		t.now_ms          = now;
		t.main_beat_ms    = main_beat;
		t.display_beat_ms = disp_beat;
		t.display_present = present;
		return t;
	endfunction

	function automatic beat_mode_t pick_mode();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 45) return BEAT_STALE;
		if (r < 75) return BEAT_FRESH;
		if (r < 85) return BEAT_NEVER;
		return BEAT_NOISE;
	endfunction

	function automatic logic [TimeW-1:0] beat_for(beat_mode_t m, logic [TimeW-1:0] now);
		logic [TimeW-1:0] room;
		logic [TimeW-1:0] extra;
		case (m)
			BEAT_FRESH: begin
				return now - $urandom_range(wd_threshold, 0);
			end
			BEAT_STALE: begin
				// no age can exceed the largest threshold
				if (wd_threshold == '1) return $urandom;
				room  = ~wd_threshold - 32'd1;
				extra = ($urandom_range(3) == 0) ? $urandom_range(room, 0)
					: $urandom_range((room < 3) ? room : 3, 0);
				return now - wd_threshold - 32'd1 - extra;
			end
			BEAT_NEVER: begin
				return '0;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	function automatic tick_t random_tick();
		if (main_left == 0) begin
			main_mode = pick_mode();
			main_left = $urandom_range(6, 1);
		end
		if (disp_left == 0) begin
			disp_mode = pick_mode();
			disp_left = $urandom_range(6, 1);
		end
		main_left--;
		disp_left--;
		wall_ms = wall_ms + (($urandom_range(9) == 0) ? $urandom : $urandom_range(4000));
		return mk_tick(wall_ms, beat_for(main_mode, wall_ms), beat_for(disp_mode, wall_ms),
			$urandom_range(99) < 85);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("[%0t] mismatch on %s in result %0d: got 0x%0h, expected 0x%0h",
			$realtime, what, results_seen, got, want);
		mismatches++;
	endtask

	task automatic send_tick(tick_t t);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(InDataW - $bits(tick_t)){1'b0}}, t};
		do @(posedge clk); while (!s_tready);
		verdicts_due.push_back(watchdog_verdict(t));
	endtask

	// hold until every expected result is out, then let the pipeline settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (PipeDepth + 2) @(posedge clk);
	endtask

	task automatic configure(logic [31:0] thr, logic [31:0] lim, logic [31:0] autor,
			logic [31:0] ivl);
		cfg_we    <= 1'b1;
		cfg_index <= REG_STALL_THRESHOLD;
		cfg_wdata <= thr;
		@(posedge clk);
		cfg_index <= REG_HITS_LIMIT;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_index <= REG_AUTO_RESTART;
		cfg_wdata <= autor;
		@(posedge clk);
		cfg_index <= REG_SNAP_INTERVAL;
		cfg_wdata <= ivl;
		@(posedge clk);
		cfg_we <= 1'b0;
		wd_threshold = (thr < MinThresholdMs) ? MinThresholdMs : thr;
		wd_hit_limit = (lim[HitsW-1:0] == '0) ? HitsW'(1) : lim[HitsW-1:0];
		wd_auto      = autor[0];
		wd_interval  = (ivl != '0 && ivl < MinIntervalMs) ? MinIntervalMs : ivl;
	endtask

	task automatic set_idling(int unsigned snd, int unsigned rcv);
		snd_idle_pct  = snd;
		rcv_stall_pct = rcv;
	endtask

	// output side: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[ResW-1:0];
			if (verdicts_due.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[31:0], '0);
			end else begin
				want = verdicts_due.pop_front();
				if (got.main_hits != want.main_hits)
					report_mismatch("main_hits", 32'(got.main_hits), 32'(want.main_hits));
				if (got.display_hits != want.display_hits)
					report_mismatch("display_hits", 32'(got.display_hits),
						32'(want.display_hits));
				if (got.restart_request != want.restart_request)
					report_mismatch("restart_request", 32'(got.restart_request),
						32'(want.restart_request));
				if (got.restart_cause != want.restart_cause)
					report_mismatch("restart_cause", 32'(got.restart_cause),
						32'(want.restart_cause));
				if (got.snapshot_due != want.snapshot_due)
					report_mismatch("snapshot_due", 32'(got.snapshot_due),
						32'(want.snapshot_due));
				if (got.restart_total != want.restart_total)
					report_mismatch("restart_total", 32'(got.restart_total),
						32'(want.restart_total));
				if (m_tdata[OutDataW-1:ResW] != '0)
					report_mismatch("zero fill", 32'(m_tdata[OutDataW-1:ResW]), '0);
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= QuietLimit) begin
			$display("[%0t] no transaction for %0d cycles", $realtime, quiet_cycles);
			$display("tb_heartbeat_stall_watchdog_top: FAIL");
			$finish;
		end
	end

	task automatic test_reset_defaults();
		send_tick(mk_tick('0, '0, '0, 1'b1));
		send_tick(mk_tick('1, '1, 32'd1, 1'b0));
	endtask

	// display stale as well, so a skipped display check shows
	task automatic test_main_restart();
		for (int i = 1; i <= 4; i++)
			send_tick(mk_tick(32'(200000 * i), 32'd1, 32'd2, 1'b1));
	endtask

	task automatic test_display_restart();
		logic [TimeW-1:0] now;
		for (int i = 0; i < 4; i++) begin
			now = 32'(2000000 + 200000 * i);
			send_tick(mk_tick(now, now - 32'd5, 32'd7, i != 3));
		end
	endtask

	task automatic test_age_wrap();
		send_tick(mk_tick(32'd10, 32'hFFFF_0000, '0, 1'b0));
		send_tick(mk_tick(32'd70000, 32'd10000, '0, 1'b0));
		send_tick(mk_tick(32'd70001, 32'd10000, '0, 1'b0));
		send_tick(mk_tick(32'd100, 32'd200, 32'd300, 1'b1));
	endtask

	task automatic test_config_clamps();
		drain();
		configure('0, '0, 32'hFFFF_FFFE, 32'd1);
		send_tick(mk_tick(32'd50000, 32'd49000, 32'd48999, 1'b1));
		send_tick(mk_tick(32'd50001, 32'd49000, 32'd48999, 1'b1));
		drain();
		configure(32'd999, 32'hFFFF_FFFF, 32'd1, 32'd4999);
		send_tick(mk_tick(32'd60000, 32'd58999, '0, 1'b0));
		drain();
		configure('1, 32'd1, 32'd1, '0);
		send_tick(mk_tick('0, 32'd1, 32'd2, 1'b1));
		send_tick(mk_tick(32'h8000_0000, 32'd1, 32'd2, 1'b1));
		drain();
		configure(RstThresholdMs, 32'(RstHitsLimit), 32'd1, RstIntervalMs);
	endtask

	task automatic test_random_traffic();
		logic [31:0] thr;
		logic [31:0] lim;
		logic [31:0] autor;
		logic [31:0] ivl;
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case (ph)
				0: begin
					configure('0, '0, 32'd1, 32'd1);
				end
				1: begin
					configure('1, '1, '1, '1);
				end
				default: begin
					thr   = ($urandom_range(3) == 0) ? $urandom_range(1500)
						: $urandom_range(30000, 1000);
					lim   = ($urandom_range(4) == 0) ? $urandom : $urandom_range(6);
					autor = ($urandom & 32'hFFFF_FFFE) | ($urandom_range(3) != 0);
					case ($urandom_range(2))
						0: ivl = '0;
						1: ivl = $urandom_range(4999, 1);
						default: ivl = $urandom_range(20000, 5000);
					endcase
					configure(thr, lim, autor, ivl);
				end
			endcase
			case (ph % 4)
				0: set_idling(0, 0);
				1: set_idling(74, 0);
				2: set_idling(0, 74);
				default: set_idling(21, 21);
			endcase
			for (int i = 0; i < 45; i++) send_tick(random_tick());
		end
	endtask

	// stall the output long enough that both pipeline stages fill and s_tready drops
	task automatic test_backpressure();
		drain();
		set_idling(0, 0);
		hold_req = HoldCycles;
		for (int i = 0; i < 24; i++) send_tick(random_tick());
	endtask

	task automatic test_counter_saturation();
		logic [TimeW-1:0] now;
		drain();
		set_idling(0, 0);
		configure(RstThresholdMs, 32'd255, '0, '0);
		// start well clear of zero so the stale beat never reads as unseen
		wall_ms = 32'h8000_0000;
		for (int i = 0; i < 260; i++) begin
			now = wall_ms;
			wall_ms = wall_ms + 32'd1;
			send_tick(mk_tick(now, now - 32'd100000, now - 32'd100000, 1'b1));
		end
		drain();
		configure(MinThresholdMs, 32'd1, 32'd1, '0);
		// a hit limit of one restarts on every stale tick
		for (int i = 0; i < 4; i++) begin
			now = wall_ms;
			wall_ms = wall_ms + 32'd1;
			send_tick(mk_tick(now, now - 32'd100000, '0, 1'b1));
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		m_tready      = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_STALL_THRESHOLD;
		cfg_wdata     = '0;
		mismatches    = 0;
		results_seen  = 0;
		quiet_cycles  = 0;
		hold_req      = 0;
		hold_left     = 0;
		wall_ms       = $urandom;
		main_left     = 0;
		disp_left     = 0;
		main_mode     = BEAT_FRESH;
		disp_mode     = BEAT_FRESH;
		wd_threshold  = RstThresholdMs;
		wd_hit_limit  = RstHitsLimit;
		wd_auto       = 1'b1;
		wd_interval   = RstIntervalMs;
		wd_main_hits  = '0;
		wd_disp_hits  = '0;
		wd_last_snap  = '0;
		wd_restarts   = '0;
		set_idling(0, 0);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_main_restart();
		test_display_restart();
		test_age_wrap();
		test_config_clamps();
		test_random_traffic();
		test_backpressure();
		test_counter_saturation();
		drain();

		if (mismatches == 0) begin
			$display("tb_heartbeat_stall_watchdog_top: PASS");
		end else begin
			$display("tb_heartbeat_stall_watchdog_top: FAIL");
		end
		$finish;
	end

endmodule
